/* rtl/c2t_pkg.sv */
// c2t_pkg: shared types and constants of the CSV to TSV stream converter.
// No dependencies; imported by every module of the block except c2t_fifo.
`default_nettype none
package c2t_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int MID_DEPTH_DEFAULT  = 2;
    localparam int OUT_DEPTH_DEFAULT  = 2;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int          PADDR_W             = 2;
    localparam logic [1:0]  REG_OUTPUT_LIMIT    = 2'd0;
    localparam logic [15:0] OUTPUT_LIMIT_RESET  = 16'hFFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_char;
        logic       last;
        logic       is_nl;
        logic       is_comma;
        logic       is_quote;
    } mid_item_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_char;
        logic        out_done;
        logic [15:0] out_count;
    } result_t;

endpackage
`default_nettype wire

/* rtl/c2t_fifo.sv */
// c2t_fifo: small register-based FIFO with push/full and pop/empty sides.
// Depends on nothing; used for the classify queue and the result queue.
`default_nettype none
module c2t_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

/* rtl/c2t_front.sv */
// c2t_front: accepts input transactions, classifies each byte, queues it.
// Depends on c2t_pkg and c2t_fifo.
`default_nettype none
module c2t_front
    import c2t_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire in_item_t  item,
    output logic           full,
    input  wire logic      mid_pop,
    output mid_item_t      mid_item,
    output logic           mid_empty
);

    mid_item_t cls;

    always_comb
    begin
        cls.data_char = (item.in_byte == CH_TAB) ? CH_SPACE : item.in_byte;
        cls.last      = item.in_last;
        cls.is_nl     = (item.in_byte == CH_NL);
        cls.is_comma  = (item.in_byte == CH_COMMA);
        cls.is_quote  = (item.in_byte == CH_QUOTE);
    end

    c2t_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_item),
        .empty (mid_empty)
    );

endmodule
`default_nettype wire

/* rtl/c2t_back.sv */
// c2t_back: field mode machine, emitted count and limit; queues results.
// Depends on c2t_pkg and c2t_fifo.
`default_nettype none
module c2t_back
    import c2t_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
    parameter int OUT_DEPTH  = OUT_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] output_limit,
    input  wire mid_item_t   mid_item,
    input  wire logic        mid_empty,
    output logic             mid_pop,
    output logic             empty,
    input  wire logic        pop,
    output result_t          result
);

    localparam logic [1:0] MODE_BETWEEN    = 2'd0;
    localparam logic [1:0] MODE_PLAIN      = 2'd1;
    localparam logic [1:0] MODE_QUOTED     = 2'd2;
    localparam logic [1:0] MODE_QUOTE_SEEN = 2'd3;

    localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [LW-1:0] CMAX = LW'((64'd1 << COUNT_BITS) - 64'd1);

    logic [1:0]            mode_reg, mode_next, mode_adv;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  hit_reg, hit_next;
    logic                  out_full, emit, hit_now;
    logic [7:0]            ch;
    logic [LW-1:0]         limit_w, lim, cnt_w, cnt_next_w;
    result_t               res;

    assign mid_pop = !mid_empty && !out_full;
    assign limit_w = LW'(output_limit);
    assign lim     = (limit_w > CMAX) ? CMAX : limit_w;
    assign cnt_w   = LW'(cnt_reg);
    assign hit_now = hit_reg || (cnt_w >= lim);

    always_comb
    begin
        mode_adv = mode_reg;
        emit     = 1'b1;
        ch       = mid_item.data_char;
        if (mid_item.is_nl)
        begin
            mode_adv = MODE_BETWEEN;
            ch       = CH_NL;
        end
        else
        begin
            unique case (mode_reg)
                MODE_BETWEEN:
                begin
                    if (mid_item.is_comma)
                    begin
                        ch = CH_TAB;
                    end
                    else if (mid_item.is_quote)
                    begin
                        mode_adv = MODE_QUOTED;
                        emit     = 1'b0;
                    end
                    else
                    begin
                        mode_adv = MODE_PLAIN;
                    end
                end
                MODE_PLAIN:
                begin
                    if (mid_item.is_comma)
                    begin
                        mode_adv = MODE_BETWEEN;
                        ch       = CH_TAB;
                    end
                end
                MODE_QUOTED:
                begin
                    if (mid_item.is_quote)
                    begin
                        if (mid_item.last)
                        begin
                            mode_adv = MODE_BETWEEN;
                            ch       = CH_TAB;
                        end
                        else
                        begin
                            mode_adv = MODE_QUOTE_SEEN;
                            emit     = 1'b0;
                        end
                    end
                end
                MODE_QUOTE_SEEN:
                begin
                    if (mid_item.is_comma)
                    begin
                        mode_adv = MODE_BETWEEN;
                        ch       = CH_TAB;
                    end
                    else
                    begin
                        mode_adv = MODE_QUOTED;
                    end
                end
                default:
                begin
                    mode_adv = MODE_BETWEEN;
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        hit_next  = 1'b1;
        if (!hit_now)
        begin
            mode_next = mode_adv;
            cnt_next  = cnt_reg + COUNT_BITS'(emit);
        end
        cnt_next_w = LW'(cnt_next);
        if (!hit_now)
        begin
            hit_next = (cnt_next_w >= lim);
        end
        res.out_valid = !hit_now && emit;
        res.out_char  = (!hit_now && emit) ? ch : 8'h00;
        res.out_done  = hit_next || mid_item.last;
        res.out_count = cnt_next_w[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BETWEEN;
            cnt_reg  <= '0;
            hit_reg  <= 1'b0;
        end
        else if (mid_pop)
        begin
            if (mid_item.last)
            begin
                mode_reg <= MODE_BETWEEN;
                cnt_reg  <= '0;
                hit_reg  <= 1'b0;
            end
            else
            begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
                hit_reg  <= hit_next;
            end
        end
    end

    c2t_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_pop),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule
`default_nettype wire

/* rtl/csv_to_tsv_stream_converter_top.sv */
// csv_to_tsv_stream_converter_top: APB register, classify front, mode back.
// Depends on c2t_pkg, c2t_front, c2t_back (and c2t_fifo below them).
//
// channel   direction  handshake                     payload
// input     in         push / full                   item   (in_item_t)
// result    out        empty / pop                   result (result_t)
// config    in/out     psel penable pwrite pready    paddr pwdata prdata
//
// One byte per cycle sustained while results are popped; each transaction yields
// exactly one result. From push to result visible, an item passes the classify
// queue, then the mode/count update writing the result queue. Either side may
// stall on its own; full rises only when both two-entry queues are filled.
// Reset clears the queues, mode, count and limit flag; output_limit = 65535.
`default_nettype none
module csv_to_tsv_stream_converter_top
    import c2t_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire in_item_t           item,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output result_t                 result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [15:0] output_limit_reg;
    mid_item_t   mid_item;
    logic        mid_empty, mid_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_OUTPUT_LIMIT) ? {16'h0000, output_limit_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_limit_reg <= OUTPUT_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_OUTPUT_LIMIT))
        begin
            output_limit_reg <= pwdata[15:0];
        end
    end

    c2t_front #(
        .MID_DEPTH (MID_DEPTH_DEFAULT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .mid_pop   (mid_pop),
        .mid_item  (mid_item),
        .mid_empty (mid_empty)
    );

    c2t_back #(
        .COUNT_BITS (COUNT_BITS),
        .OUT_DEPTH  (OUT_DEPTH_DEFAULT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .output_limit (output_limit_reg),
        .mid_item     (mid_item),
        .mid_empty    (mid_empty),
        .mid_pop      (mid_pop),
        .empty        (empty),
        .pop          (pop),
        .result       (result)
    );

endmodule
`default_nettype wire

/* dv/tb_csv_to_tsv_stream_converter_top.sv */
// Self-checking testbench for csv_to_tsv_stream_converter_top: CSV bytes in, TSV results out,
// each result compared against an in-bench converter model; output_limit set over APB.
// Depends on c2t_pkg and the RTL of the block only.
`timescale 1ns / 100ps
module tb_csv_to_tsv_stream_converter_top;
    import c2t_pkg::*;

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_QUOTE_SEEN
    } field_mode_e;

    logic                clk;
    logic                rst_n;
    logic                push;
    in_item_t            item;
    logic                full;
    logic                empty;
    logic                pop;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    field_mode_e         conv_mode;
    logic [15:0]         conv_count;
    logic [15:0]         conv_limit;
    logic                conv_limit_hit;
    result_t             pending_tsv[$];
    int                  fail_count;
    bit                  no_gaps;
    int                  hold_request;
    int                  hold_left;

    csv_to_tsv_stream_converter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] as_data(logic [7:0] b);
        return (b == CH_TAB) ? CH_SPACE : b;
    endfunction

    function automatic result_t predict_tsv_byte(in_item_t it);
        result_t     r;
        logic [7:0]  b;
        logic [7:0]  ch;
        logic        emit;
        b    = it.in_byte;
        ch   = 8'h00;
        emit = 1'b0;
        if (conv_count >= conv_limit)
            conv_limit_hit = 1'b1;
        if (!conv_limit_hit)
        begin
            if (b == CH_NL)
            begin
                conv_mode = MODE_BETWEEN;
                ch        = CH_NL;
                emit      = 1'b1;
            end
            else
            begin
                case (conv_mode)
                    MODE_BETWEEN:
                    begin
                        if (b == CH_COMMA)
                        begin
                            ch   = CH_TAB;
                            emit = 1'b1;
                        end
                        else if (b == CH_QUOTE)
                            conv_mode = MODE_QUOTED;
                        else
                        begin
                            conv_mode = MODE_PLAIN;
                            ch        = as_data(b);
                            emit      = 1'b1;
                        end
                    end
                    MODE_PLAIN:
                    begin
                        if (b == CH_COMMA)
                        begin
                            conv_mode = MODE_BETWEEN;
                            ch        = CH_TAB;
                        end
                        else
                            ch = as_data(b);
                        emit = 1'b1;
                    end
                    MODE_QUOTED:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            if (it.in_last)
                            begin
                                conv_mode = MODE_BETWEEN;
                                ch        = CH_TAB;
                                emit      = 1'b1;
                            end
                            else
                                conv_mode = MODE_QUOTE_SEEN;
                        end
                        else
                        begin
                            ch   = as_data(b);
                            emit = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (b == CH_COMMA)
                        begin
                            conv_mode = MODE_BETWEEN;
                            ch        = CH_TAB;
                        end
                        else
                        begin
                            // doubled quote keeps one; otherwise the quote is dropped
                            conv_mode = MODE_QUOTED;
                            ch        = as_data(b);
                        end
                        emit = 1'b1;
                    end
                endcase
            end
            if (emit)
                conv_count = conv_count + 16'd1;
            if (conv_count >= conv_limit)
                conv_limit_hit = 1'b1;
        end
        r.out_valid = emit;
        r.out_char  = emit ? ch : 8'h00;
        r.out_done  = conv_limit_hit || it.in_last;
        r.out_count = conv_count;
        if (it.in_last)
        begin
            conv_mode      = MODE_BETWEEN;
            conv_count     = '0;
            conv_limit_hit = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // receiver: random pop, plus a counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= no_gaps || ($urandom_range(99) >= 28);
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && pop && !empty)
        begin
            if (pending_tsv.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %0h", $time, result);
                fail_count++;
            end
            else
            begin
                exp_r = pending_tsv.pop_front();
                check_field("out_valid", exp_r.out_valid, result.out_valid);
                check_field("out_char", exp_r.out_char, result.out_char);
                check_field("out_done", exp_r.out_done, result.out_done);
                check_field("out_count", exp_r.out_count, result.out_count);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic mark_last);
        in_item_t it;
        it.in_byte   = b;
        it.in_last   = mark_last;
        @(negedge clk);
        if (!no_gaps && $urandom_range(99) < 28)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_tsv.push_back(predict_tsv_byte(it));
    endtask

    task automatic end_burst();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic send_text(input string s, input bit mark_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], mark_last && (i == s.len() - 1));
        end_burst();
    endtask

    task automatic drain();
        while (pending_tsv.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_output_limit(input logic [15:0] value);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_OUTPUT_LIMIT;
        pwdata  <= {16'h0000, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        conv_limit = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("output_limit readback", value, prdata[15:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] rand_plain_char();
        logic [7:0] c;
        case ($urandom_range(9))
            0: c = CH_TAB;
            1: c = CH_QUOTE;
            2: c = CH_SPACE;
            3:
            begin
                c = 8'($urandom_range(255));
                if (c == CH_NL || c == CH_COMMA)
                    c = "x";
            end
            default: c = 8'("a" + $urandom_range(25));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] rand_quoted_char();
        case ($urandom_range(11))
            0: return CH_COMMA;
            1: return CH_TAB;
            2: return (($urandom_range(5) == 0) ? CH_NL : CH_SPACE);
            3: return 8'($urandom_range(255));
            default: return 8'("A" + $urandom_range(25));
        endcase
    endfunction

    // mostly well-formed records with random content, some stray bytes
    task automatic send_random_stream(output int n_sent);
        logic [7:0] csv[$];
        int         n_rec;
        int         n_fld;
        int         kind;
        n_rec = $urandom_range(1, 3);
        for (int r = 0; r < n_rec; r++)
        begin
            n_fld = $urandom_range(1, 4);
            for (int f = 0; f < n_fld; f++)
            begin
                if (f > 0)
                    csv.push_back(CH_COMMA);
                kind = $urandom_range(9);
                if (kind >= 2 && kind < 6)
                begin
                    repeat ($urandom_range(1, 6))
                        csv.push_back(rand_plain_char());
                end
                else if (kind >= 6)
                begin
                    csv.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 6))
                    begin
                        if ($urandom_range(6) == 0)
                        begin
                            csv.push_back(CH_QUOTE);
                            csv.push_back(CH_QUOTE);
                        end
                        else
                            csv.push_back(rand_quoted_char());
                    end
                    csv.push_back(CH_QUOTE);
                end
                if ($urandom_range(9) == 0)
                    csv.push_back(8'($urandom_range(255)));
            end
            if (r < n_rec - 1 || $urandom_range(1) == 1)
                csv.push_back(CH_NL);
        end
        for (int i = 0; i < csv.size(); i++)
            send_byte(csv[i], i == csv.size() - 1);
        end_burst();
        n_sent = csv.size();
    endtask

    task automatic test_directed_syntax();
        send_text("a,b\tc\n", 1'b0);
        send_text(",\"x\"\"y\",\"p\"q\"\n", 1'b0);
        send_text("z\"w", 1'b1);
        send_text("\"\t\"", 1'b1);
        send_text(",\"", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        end_burst();
    endtask

    task automatic test_output_limit();
        write_output_limit(16'd3);
        send_text("ab,cdef", 1'b0);
        send_text("x", 1'b1);
        write_output_limit(16'd1);
        send_text("\"q\"", 1'b1);
        write_output_limit(16'd0);
        send_text("abc", 1'b1);
        write_output_limit(16'hFFFF);
        send_text("hello,wo", 1'b0);
        write_output_limit(16'd4);  // below the running count
        send_text("rld\n", 1'b0);
        send_text("!", 1'b1);
        write_output_limit(16'hFFFF);
    endtask

    task automatic test_random_streams();
        int total;
        int n;
        int stream_idx;
        total      = 0;
        stream_idx = 0;
        while (total < 500)
        begin
            case ($urandom_range(5))
                0: write_output_limit(16'($urandom_range(1, 8)));
                1: write_output_limit(16'($urandom_range(9, 40)));
                2: write_output_limit(16'($urandom_range(41, 65535)));
                default: write_output_limit(16'hFFFF);
            endcase
            no_gaps = (stream_idx >= 5 && stream_idx < 10);
            send_random_stream(n);
            total += n;
            stream_idx++;
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure();
        write_output_limit(16'hFFFF);
        no_gaps      = 1'b1;
        hold_request = 120;
        for (int i = 0; i < 40; i++)
            send_byte(8'("a" + (i % 26)), i == 39);
        end_burst();
        no_gaps = 1'b0;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        item           = '0;
        pop            = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        conv_mode      = MODE_BETWEEN;
        conv_count     = '0;
        conv_limit     = OUTPUT_LIMIT_RESET;
        conv_limit_hit = 1'b0;
        fail_count     = 0;
        no_gaps        = 1'b0;
        hold_request   = 0;
        hold_left      = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_syntax();
        test_output_limit();
        test_backpressure();
        test_random_streams();

        while (pending_tsv.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_tsv.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* csv_to_tsv_stream_converter_top.f */
rtl/c2t_pkg.sv
rtl/c2t_fifo.sv
rtl/c2t_front.sv
rtl/c2t_back.sv
rtl/csv_to_tsv_stream_converter_top.sv
dv/tb_csv_to_tsv_stream_converter_top.sv
